@@ sv/megm_pkg.sv @@
// megm_pkg: widths, register indexes, item types and controller/datapath
// command and status structs for the memory expansion gas meter
// no dependencies
package megm_pkg;

	// fixed field widths
	localparam int GasFieldW   = 63;
	localparam int MemW        = 64;
	localparam int WordGasW    = 8;
	localparam int DivW        = 16;
	localparam int GasWidthDef = 63;

	// 32-byte memory words
	localparam int WordBytes = 32;
	localparam int WordMask  = 31;
	localparam int WordShift = $clog2(WordBytes);
	localparam int WordW     = MemW - WordShift;

	// a word count at or above 2^WordCapW gives words^2/divisor >= 2^64,
	// beyond any gas limit, so the cost unit only squares narrower counts
	localparam int WordCapW = 40;
	localparam int HalfW    = WordCapW / 2;
	localparam int PpW      = 2 * HalfW;
	localparam int ProdW    = 2 * WordCapW;
	localparam int LinW     = WordGasW + WordCapW;
	localparam int CostW    = ProdW + 1;

	// copy charge and running total
	localparam int CopyWordsW = WordW + 1;
	localparam int CopyProdW  = WordGasW + CopyWordsW;
	localparam int TotW       = CopyProdW + 2;

	// sequencing of the shared cost unit
	localparam int MulSteps     = 5;
	localparam int DivRadixBits = 4;
	localparam int DivSteps     = ProdW / DivRadixBits;
	localparam int CntW         = $clog2(DivSteps);

	// configuration port
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = DivW;
	localparam logic [CfgIdxW-1:0] CFG_WORD_GAS  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_QUAD_DIV  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_COPY_GAS  = 2'd2;

	localparam logic [WordGasW-1:0] WordGasRst = 8'd3;
	localparam logic [DivW-1:0]     QuadDivRst = 16'd512;
	localparam logic [WordGasW-1:0] CopyGasRst = 8'd3;

	// item function codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_CHARGE = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [GasFieldW-1:0] gas_budget;
		logic [GasFieldW-1:0] base_gas;
		logic [MemW-1:0]      mem_offset;
		logic [MemW-1:0]      mem_length;
		logic [MemW-1:0]      copy_length;
	} item_t;

	typedef struct packed {
		logic                 out_of_gas;
		logic [GasFieldW-1:0] step_gas;
		logic [GasFieldW-1:0] gas_remaining;
		logic [MemW-1:0]      memory_bytes;
	} result_t;

	typedef struct packed {
		logic            latch;
		logic            win;
		logic            cost_init;
		logic            mul;
		logic            div;
		logic            cost_sum;
		logic            cost_sel;
		logic            copy;
		logic            fin;
		logic [CntW-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic item_func;
		logic sat;
		logic grow;
		logic over;
		logic out_free;
	} stat_t;

endpackage

@@ sv/megm_if.sv @@
// megm_item_if and megm_result_if: valid/ready channels for the gas meter
// depends on megm_pkg for the item and result types
interface megm_item_if;
	import megm_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface megm_result_if;
	import megm_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ sv/megm_ctrl.sv @@
// megm_ctrl: sequencer of the gas meter, steps the datapath through
// window, memory cost, copy and final deduction; depends on megm_pkg
module megm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  megm_pkg::stat_t stat,
	output megm_pkg::cmd_t  cmd
);
	import megm_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WIN   = 4'd1;
	localparam logic [3:0] S_PLAN  = 4'd2;
	localparam logic [3:0] S_CINIT = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_CSUM  = 4'd6;
	localparam logic [3:0] S_COPY  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0]      state_q, state_d;
	logic [CntW-1:0] step_q, step_d;
	logic            sel_q, sel_d;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		sel_d    = sel_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.cost_sel = sel_q;
		cmd.step     = step_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = (stat.item_func == FUNC_CHARGE) ? S_WIN : S_FIN;
				end
			end
			S_WIN: begin
				cmd.win = 1'b1;
				state_d = S_PLAN;
			end
			S_PLAN: begin
				if (stat.sat) begin
					state_d = S_FIN;
				end else if (stat.grow) begin
					sel_d   = 1'b0;
					state_d = S_CINIT;
				end else begin
					state_d = S_COPY;
				end
			end
			S_CINIT: begin
				cmd.cost_init = 1'b1;
				step_d        = '0;
				state_d       = (stat.sat || stat.over) ? S_FIN : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (step_q == CntW'(MulSteps - 1)) begin
					step_d  = '0;
					state_d = S_DIV;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (step_q == CntW'(DivSteps - 1)) begin
					step_d  = '0;
					state_d = S_CSUM;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_CSUM: begin
				cmd.cost_sum = 1'b1;
				if (sel_q) begin
					state_d = S_COPY;
				end else begin
					sel_d   = 1'b1;
					state_d = S_CINIT;
				end
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sel_q   <= sel_d;
		end
	end

endmodule

@@ sv/megm_datapath.sv @@
// megm_datapath: configuration, gas and memory state, shared cost unit
// (split square, radix-16 divider) and result register; depends on megm_pkg
module megm_datapath #(
	parameter int GAS_WIDTH = megm_pkg::GasWidthDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [megm_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [megm_pkg::CfgDataW-1:0]   cfg_data,
	input  megm_pkg::item_t                 item_data,
	input  megm_pkg::cmd_t                  cmd,
	output megm_pkg::stat_t                 stat,
	input  logic                            out_ready,
	output logic                            out_valid,
	output megm_pkg::result_t               out_data
);
	import megm_pkg::*;

	localparam logic [GAS_WIDTH-1:0] GasMax    = '1;
	localparam logic [GasFieldW-1:0] GasMaxFld = GasFieldW'(GasMax);
	localparam logic [MemW:0]        GasMaxWin = (MemW + 1)'(GasMax);
	localparam logic [CostW-1:0]     GasMaxCst = CostW'(GasMax);
	localparam logic [TotW-1:0]      GasMaxTot = TotW'(GasMax);

	// configuration and architectural state
	logic [WordGasW-1:0]  word_gas_q, copy_gas_q;
	logic [DivW-1:0]      quad_div_q;
	logic [GAS_WIDTH-1:0] gas_left_q;
	logic [MemW-1:0]      mem_size_q;
	logic                 out_valid_q;

	// working registers
	logic                 func_q;
	logic [GasFieldW-1:0] budget_q, base_q;
	logic [MemW-1:0]      off_q, len_q, cp_q;
	logic                 sat_q;
	logic [MemW-1:0]      newsz_q;
	logic [TotW-1:0]      total_q;
	logic [GAS_WIDTH-1:0] cn_q;
	logic [WordCapW-1:0]  w_q;
	logic [LinW-1:0]      lin_q;
	logic [ProdW-1:0]     pp_q, prod_q;
	logic [DivW-1:0]      rem_q;
	result_t              out_q;

	// window
	logic [MemW:0]   win_sum;
	logic            win_over;
	logic [MemW-1:0] need, need_up, newsz;

	assign win_sum  = {1'b0, off_q} + {1'b0, len_q};
	assign win_over = (len_q != '0) && (win_sum > GasMaxWin);
	assign need     = (len_q != '0) ? win_sum[MemW-1:0] : '0;
	assign need_up  = need + MemW'(WordMask);
	assign newsz    = need_up & ~MemW'(WordMask);

	// cost operand
	logic [MemW-1:0]  cost_bytes;
	logic [WordW-1:0] cost_words;
	logic             cost_over;

	assign cost_bytes = cmd.cost_sel ? mem_size_q : newsz_q;
	assign cost_words = cost_bytes[MemW-1:WordShift];
	assign cost_over  = |cost_words[WordW-1:WordCapW];

	// square by 20-bit halves, one partial product a step
	logic [HalfW-1:0] mul_a, mul_b;
	logic [PpW-1:0]   pp;
	logic [ProdW-1:0] pp_shift;

	assign mul_a = cmd.step[1] ? w_q[WordCapW-1:HalfW] : w_q[HalfW-1:0];
	assign mul_b = cmd.step[0] ? w_q[WordCapW-1:HalfW] : w_q[HalfW-1:0];
	assign pp    = PpW'(mul_a) * PpW'(mul_b);

	always_comb begin
		case (cmd.step[1:0])
			2'd0:    pp_shift = ProdW'(pp);
			2'd3:    pp_shift = ProdW'(pp) << (2 * HalfW);
			default: pp_shift = ProdW'(pp) << HalfW;
		endcase
	end

	// restoring division, four quotient bits a step
	logic [DivW-1:0]  divisor;
	logic [DivW-1:0]  rem_d;
	logic [ProdW-1:0] quo_d;

	assign divisor = (quad_div_q == '0) ? DivW'(1) : quad_div_q;

	always_comb begin
		logic [DivW:0]    r17;
		logic [DivW-1:0]  r;
		logic [ProdW-1:0] p;
		r = rem_q;
		p = prod_q;
		for (int i = 0; i < DivRadixBits; i++) begin
			r17 = {r, p[ProdW-1]};
			p   = p << 1;
			if (r17 >= {1'b0, divisor}) begin
				r17  = r17 - {1'b0, divisor};
				p[0] = 1'b1;
			end
			r = r17[DivW-1:0];
		end
		rem_d = r;
		quo_d = p;
	end

	// cost = linear term + quotient
	logic [CostW-1:0]     cost;
	logic                 cost_sat;
	logic [GAS_WIDTH-1:0] cost_val;

	assign cost     = CostW'(lin_q) + CostW'(prod_q);
	assign cost_sat = cost > GasMaxCst;
	assign cost_val = cost[GAS_WIDTH-1:0];

	// copy charge
	logic [CopyWordsW-1:0] copy_words;
	logic [CopyProdW-1:0]  copy_gas;

	assign copy_words = {1'b0, cp_q[MemW-1:WordShift]}
		+ CopyWordsW'(|(cp_q & MemW'(WordMask)));
	assign copy_gas = CopyProdW'(copy_gas_q) * CopyProdW'(copy_words);

	// final deduction
	logic                 grow, fin_sat, oog;
	logic [GAS_WIDTH-1:0] step_val, budget_sat, gl_next;
	logic [MemW-1:0]      mem_next;
	result_t              res_next;

	assign grow       = newsz_q > mem_size_q;
	assign fin_sat    = sat_q || (total_q > GasMaxTot);
	assign step_val   = fin_sat ? GasMax : total_q[GAS_WIDTH-1:0];
	assign oog        = fin_sat || (step_val > gas_left_q);
	assign budget_sat = (budget_q > GasMaxFld) ? GasMax : budget_q[GAS_WIDTH-1:0];

	always_comb begin
		if (func_q == FUNC_LOAD) begin
			gl_next  = budget_sat;
			mem_next = '0;
			res_next.out_of_gas    = 1'b0;
			res_next.step_gas      = '0;
		end else begin
			gl_next  = oog ? gas_left_q : gas_left_q - step_val;
			mem_next = (!oog && grow) ? newsz_q : mem_size_q;
			res_next.out_of_gas    = oog;
			res_next.step_gas      = GasFieldW'(step_val);
		end
		res_next.gas_remaining = GasFieldW'(gl_next);
		res_next.memory_bytes  = mem_next;
	end

	assign stat.item_func = item_data.func;
	assign stat.sat       = sat_q;
	assign stat.grow      = grow;
	assign stat.over      = cost_over;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_gas_q  <= WordGasRst;
			quad_div_q  <= QuadDivRst;
			copy_gas_q  <= CopyGasRst;
			gas_left_q  <= '0;
			mem_size_q  <= '0;
			out_valid_q <= 1'b0;
			sat_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WORD_GAS: word_gas_q <= cfg_data[WordGasW-1:0];
					CFG_QUAD_DIV: quad_div_q <= cfg_data[DivW-1:0];
					CFG_COPY_GAS: copy_gas_q <= cfg_data[WordGasW-1:0];
					default: ;
				endcase
			end
			if (cmd.latch) begin
				sat_q <= 1'b0;
			end else if (cmd.win) begin
				sat_q <= win_over;
			end else if (cmd.cost_init && cost_over) begin
				sat_q <= 1'b1;
			end else if (cmd.cost_sum) begin
				if (cost_sat || (cmd.cost_sel && (cn_q < cost_val))) begin
					sat_q <= 1'b1;
				end
			end
			if (cmd.fin) begin
				gas_left_q  <= gl_next;
				mem_size_q  <= mem_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q   <= item_data.func;
			budget_q <= item_data.gas_budget;
			base_q   <= item_data.base_gas;
			off_q    <= item_data.mem_offset;
			len_q    <= item_data.mem_length;
			cp_q     <= item_data.copy_length;
		end
		if (cmd.win) begin
			newsz_q <= newsz;
			total_q <= TotW'(base_q);
		end
		if (cmd.cost_init) begin
			w_q    <= cost_words[WordCapW-1:0];
			lin_q  <= LinW'(word_gas_q) * LinW'(cost_words[WordCapW-1:0]);
			pp_q   <= '0;
			prod_q <= '0;
			rem_q  <= '0;
		end
		if (cmd.mul) begin
			pp_q   <= pp_shift;
			prod_q <= prod_q + pp_q;
		end
		if (cmd.div) begin
			prod_q <= quo_d;
			rem_q  <= rem_d;
		end
		if (cmd.cost_sum && !cost_sat) begin
			if (!cmd.cost_sel) begin
				cn_q <= cost_val;
			end else if (cn_q >= cost_val) begin
				total_q <= total_q + TotW'(cn_q - cost_val);
			end
		end
		if (cmd.copy) begin
			total_q <= total_q + TotW'(copy_gas);
		end
		if (cmd.fin) begin
			out_q <= res_next;
		end
	end

endmodule

@@ sv/memory_expansion_gas_meter.sv @@
// memory_expansion_gas_meter: top level of the instruction gas meter
// depends on megm_pkg, megm_if, megm_ctrl and megm_datapath
//
// Charges gas for one instruction per item. A load item (func 0) sets the
// remaining gas, saturated to 2^GAS_WIDTH-1, and clears the memory size; a
// charge item (func 1) adds base gas, the memory expansion cost
// cost(new)-cost(old) with cost(b) = word_gas*w + w*w/quad_divisor, w = b/32,
// and copy_word_gas per started 32-byte copied word. Any intermediate value
// above 2^GAS_WIDTH-1 or a charge above the remaining gas flags out_of_gas
// and leaves the state alone; otherwise the gas is deducted and the memory
// grows. One item is worked at a time. A load goes from accept straight to the
// final deduction, a charge whose memory does not grow skips the cost unit, and
// a charge that grows memory runs the shared cost unit once for the new size and
// once for the old one (5 partial-product steps of the word square, then 20
// radix-16 steps of the divider). The result sits in an output register, so the
// next item is taken while it waits; configuration writes on
// cfg_we/cfg_index/cfg_data land the same cycle and are meant for idle periods
// only. A quad_divisor of zero acts as one.
module memory_expansion_gas_meter #(
	parameter int GAS_WIDTH = megm_pkg::GasWidthDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [megm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [megm_pkg::CfgDataW-1:0] cfg_data,
	megm_item_if.sink                     item,
	megm_result_if.source                 result
);
	import megm_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	// item is taken only while the sequencer is idle
	assign item.ready = in_ready;

	megm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath holds config, gas/memory state and the result register
	megm_datapath #(
		.GAS_WIDTH (GAS_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_data (item.data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_data  (result.data)
	);

endmodule

@@ test/memory_expansion_gas_meter_test.sv @@
// memory_expansion_gas_meter_test: self-checking bench for the gas meter, with
// its own gas and memory-size model, a directed opening and random phases
// depends on megm_pkg, megm_if and the memory_expansion_gas_meter rtl
module memory_expansion_gas_meter_test;
	timeunit 1ns;
	timeprecision 1ps;
	import megm_pkg::*;

	localparam logic [GasFieldW-1:0] GasMax = '1;
	localparam int PhaseItems = 125;
	localparam int NumPhases = 6;

	// one directed item, with a hand-worked result where it is obvious
	typedef struct {
		item_t   stim;
		logic    typed;
		result_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	megm_item_if item_bus();
	megm_result_if result_bus();

	memory_expansion_gas_meter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_bus),
		.result(result_bus)
	);

	always #10 clk = ~clk;

	// meter state and registers as the block should hold them
	logic [GasFieldW-1:0] budget_left;
	logic [MemW-1:0]      mem_bytes;
	logic [WordGasW-1:0]  word_fee;
	logic [DivW-1:0]      quad_div;
	logic [WordGasW-1:0]  copy_fee;

	// results owed by the block, oldest first
	result_t gas_reports[$];
	row_t    opening_items[$];
	int      errors = 0;
	int      gap_pct = 0;
	int      stall_pct = 0;
	int      stall_left = 0;

	// memory cost of a size in bytes: word_fee*w + w*w/div, w = bytes/32;
	// returns 1 when the cost does not fit the gas width
	function automatic logic expansion_cost(input logic [MemW-1:0] bytes,
			output logic [127:0] cost);
		logic [127:0] w;
		logic [127:0] d;
		w = 128'(bytes >> WordShift);
		// a zero divisor behaves as one
		d = (quad_div == '0) ? 128'd1 : 128'(quad_div);
		cost = 128'(word_fee) * w + (w * w) / d;
		return cost > 128'(GasMax);
	endfunction

	// works out the result of one item and advances the meter state
	function automatic result_t meter_item(input item_t it);
		result_t r;
		logic sat;
		logic [127:0] total;
		logic [127:0] cost_new;
		logic [127:0] cost_old;
		logic [127:0] words;
		logic [MemW:0] window;
		logic [MemW-1:0] need;
		logic [MemW-1:0] new_size;
		logic [GasFieldW-1:0] step;
		r = '0;
		sat = 1'b0;
		step = '0;
		need = '0;
		new_size = '0;
		// load: new budget, memory cleared, charge fields ignored
		if (it.func == FUNC_LOAD) begin
			budget_left = it.gas_budget;
			mem_bytes = '0;
			r.gas_remaining = budget_left;
			return r;
		end
		// zero length needs no memory whatever the offset
		if (it.mem_length != '0) begin
			window = {1'b0, it.mem_offset} + {1'b0, it.mem_length};
			if (window > 65'(GasMax))
				sat = 1'b1;
			else
				need = window[MemW-1:0];
		end
		if (!sat) begin
			total = 128'(it.base_gas);
			new_size = ((need + 64'(WordMask)) >> WordShift) << WordShift;
			if (new_size > mem_bytes) begin
				if (expansion_cost(new_size, cost_new) || expansion_cost(mem_bytes, cost_old)
						|| cost_new < cost_old)
					sat = 1'b1;
				else
					total = total + (cost_new - cost_old);
			end
			// every started 32-byte word copied is charged
			words = 128'(it.copy_length >> WordShift)
				+ ((it.copy_length[WordShift-1:0] != '0) ? 128'd1 : 128'd0);
			total = total + 128'(copy_fee) * words;
			if (total > 128'(GasMax))
				sat = 1'b1;
			else
				step = total[GasFieldW-1:0];
		end
		if (sat) begin
			// overflow anywhere saturates the step and leaves state alone
			r.out_of_gas = 1'b1;
			step = GasMax;
		end else if (step > budget_left) begin
			r.out_of_gas = 1'b1;
		end else begin
			budget_left = budget_left - step;
			if (new_size > mem_bytes)
				mem_bytes = new_size;
		end
		r.step_gas = step;
		r.gas_remaining = budget_left;
		r.memory_bytes = mem_bytes;
		return r;
	endfunction

	function automatic item_t load_of(input logic [GasFieldW-1:0] budget);
		item_t it;
		it = '0;
		it.func = FUNC_LOAD;
		it.gas_budget = budget;
		return it;
	endfunction

	function automatic item_t charge_of(input logic [GasFieldW-1:0] base,
			input logic [MemW-1:0] off, input logic [MemW-1:0] len,
			input logic [MemW-1:0] cp);
		item_t it;
		it = '0;
		it.func = FUNC_CHARGE;
		it.base_gas = base;
		it.mem_offset = off;
		it.mem_length = len;
		it.copy_length = cp;
		return it;
	endfunction

	function automatic result_t report(input logic oog, input logic [GasFieldW-1:0] step,
			input logic [GasFieldW-1:0] rem, input logic [MemW-1:0] mem);
		result_t r;
		r.out_of_gas = oog;
		r.step_gas = step;
		r.gas_remaining = rem;
		r.memory_bytes = mem;
		return r;
	endfunction

	function automatic row_t make_row(input item_t s, input logic typed, input result_t want);
		row_t r;
		r.stim = s;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random value of random magnitude
	function automatic logic [63:0] spread64();
		return rand64() >> $urandom_range(0, 63);
	endfunction

	// mostly small windows and copies that let memory grow step by step,
	// with fewer huge values that run into overflow or out of gas
	function automatic item_t random_item();
		item_t it;
		it.gas_budget = GasFieldW'(rand64());
		it.base_gas = GasFieldW'(rand64());
		it.mem_offset = rand64();
		it.mem_length = rand64();
		it.copy_length = rand64();
		if ($urandom_range(0, 99) < 7) begin
			it.func = FUNC_LOAD;
			case ($urandom_range(0, 3))
				0: it.gas_budget = GasFieldW'($urandom_range(0, 200000));
				1: it.gas_budget = GasFieldW'(spread64());
				default: it.gas_budget = GasFieldW'(rand64() >> $urandom_range(1, 24));
			endcase
			return it;
		end
		it.func = FUNC_CHARGE;
		case ($urandom_range(0, 9))
			0: it.base_gas = GasFieldW'(spread64());
			1: ;
			default: it.base_gas = GasFieldW'($urandom_range(0, 3000));
		endcase
		case ($urandom_range(0, 9))
			0, 1: it.mem_length = '0;
			7: it.mem_length = spread64();
			8: ;
			9: it.mem_length = 64'($urandom_range(1, 1 << 20));
			default: it.mem_length = 64'($urandom_range(1, 4096));
		endcase
		case ($urandom_range(0, 9))
			6: it.mem_offset = spread64();
			7: ;
			8: it.mem_offset = {1'b0, GasMax} - 64'($urandom_range(0, 4096));
			9: it.mem_offset = 64'($urandom_range(0, 1 << 24));
			default: it.mem_offset = 64'($urandom_range(0, 1 << 16));
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3: it.copy_length = '0;
			8: it.copy_length = spread64();
			9: ;
			default: it.copy_length = 64'($urandom_range(1, 8192));
		endcase
		return it;
	endfunction

	task automatic pause_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			item_bus.valid <= 1'b0;
		end
	endtask

	// offer one item, wait for the handshake and log what it owes
	task automatic send_item(input item_t it, input logic typed, input result_t want);
		result_t predicted;
		@(negedge clk);
		item_bus.valid <= 1'b1;
		item_bus.data <= it;
		@(posedge clk);
		while (item_bus.ready !== 1'b1)
			@(posedge clk);
		predicted = meter_item(it);
		gas_reports.push_back(typed ? want : predicted);
	endtask

	// stop offering items until every owed result is back
	task automatic drain();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (gas_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_WORD_GAS: word_fee = val[WordGasW-1:0];
			CFG_QUAD_DIV: quad_div = val;
			CFG_COPY_GAS: copy_fee = val[WordGasW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t %s expected %0h actual %0h", $realtime, name, want, got);
			errors++;
		end
	endtask

	// result side stalls in bursts of random length
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			result_bus.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(1, 19) - 1;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	// every accepted result against the oldest owed one
	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			if (gas_reports.size() == 0) begin
				$display("%0t result expected none actual %0h", $realtime, result_bus.data);
				errors++;
			end else begin
				want = gas_reports.pop_front();
				check_field("out_of_gas", 64'(want.out_of_gas),
					64'(result_bus.data.out_of_gas));
				check_field("step_gas", 64'(want.step_gas), 64'(result_bus.data.step_gas));
				check_field("gas_remaining", 64'(want.gas_remaining),
					64'(result_bus.data.gas_remaining));
				check_field("memory_bytes", want.memory_bytes, result_bus.data.memory_bytes);
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin : run
		logic [CfgDataW-1:0] wg;
		logic [CfgDataW-1:0] qd;
		logic [CfgDataW-1:0] cg;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_bus.valid = 1'b0;
		item_bus.data = '0;
		result_bus.ready = 1'b0;
		budget_left = '0;
		mem_bytes = '0;
		word_fee = WordGasRst;
		quad_div = QuadDivRst;
		copy_fee = CopyGasRst;

		// directed opening at the reset register values
		opening_items.push_back(make_row(charge_of(0, 0, 0, 0), 1'b1, report(0, 0, 0, 0)));
		// any charge beats the empty budget after reset
		opening_items.push_back(make_row(charge_of(1, 0, 0, 0), 1'b1, report(1, 1, 0, 0)));
		opening_items.push_back(make_row(load_of(GasMax), 1'b1, report(0, 0, GasMax, 0)));
		// zero length ignores even the largest offset
		opening_items.push_back(make_row(charge_of(5, '1, 0, 0), 1'b1,
			report(0, 5, GasMax - 5, 0)));
		// one byte needs one word: 3 gas at word_gas 3
		opening_items.push_back(make_row(charge_of(0, 0, 1, 0), 1'b1,
			report(0, 3, GasMax - 8, 32)));
		// window end past the gas width
		opening_items.push_back(make_row(charge_of(0, {1'b0, GasMax}, 1, 0), 1'b1,
			report(1, GasMax, GasMax - 8, 32)));
		opening_items.push_back(make_row(charge_of(0, '1, '1, 0), 1'b1,
			report(1, GasMax, GasMax - 8, 32)));
		// window fits but its quadratic cost does not
		opening_items.push_back(make_row(charge_of(0, 0, {1'b0, GasMax}, 0), 1'b1,
			report(1, GasMax, GasMax - 8, 32)));
		opening_items.push_back(make_row(charge_of(0, {1'b0, GasMax} - 64'd32, 32, 0),
			1'b0, '0));
		// largest copy still fits at copy gas 3
		opening_items.push_back(make_row(charge_of(0, 0, 0, '1), 1'b0, '0));
		// base plus copy just past the gas width
		opening_items.push_back(make_row(charge_of(GasMax, 0, 0, 32), 1'b0, '0));
		opening_items.push_back(make_row(charge_of(0, 31, 1, 1), 1'b0, '0));
		opening_items.push_back(make_row(charge_of(7, 32, 33, 64), 1'b0, '0));
		opening_items.push_back(make_row(load_of(0), 1'b1, report(0, 0, 0, 0)));
		opening_items.push_back(make_row(charge_of(0, 0, 0, 1), 1'b1, report(1, 3, 0, 0)));
		opening_items.push_back(make_row(load_of(100), 1'b1, report(0, 0, 100, 0)));
		// charge equal to what is left spends it all
		opening_items.push_back(make_row(charge_of(97, 0, 1, 0), 1'b1,
			report(0, 100, 0, 32)));
		opening_items.push_back(make_row(charge_of(0, 0, 0, 0), 1'b1, report(0, 0, 0, 32)));
		opening_items.push_back(make_row(load_of(63'h2AAA_AAAA_AAAA_AAAA), 1'b0, '0));
		opening_items.push_back(make_row(charge_of(63'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			0, 64'h5555_5555_5555_5555), 1'b0, '0));
		opening_items.push_back(make_row(charge_of(0, 64'h0000_0000_FFFF_FFE0, 64'h20, 0),
			1'b0, '0));
		opening_items.push_back(make_row(charge_of(0, 64'h1000, 1, 64'h1F), 1'b0, '0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		gap_pct = 15;
		stall_pct = 15;
		foreach (opening_items[i]) begin
			if ($urandom_range(0, 99) < gap_pct)
				pause_sender($urandom_range(1, 19));
			send_item(opening_items[i].stim, opening_items[i].typed, opening_items[i].want);
		end

		// random phases, each under its own register setting
		for (int phase = 0; phase < NumPhases; phase++) begin
			// registers only move while nothing is in flight
			drain();
			case (phase)
				0: begin
					wg = 16'd255;
					qd = 16'd1;
					cg = 16'd255;
				end
				1: begin
					wg = 16'd0;
					qd = 16'hFFFF;
					cg = 16'd0;
				end
				2: begin
					// divisor of zero behaves as one
					wg = 16'($urandom_range(0, 255));
					qd = 16'd0;
					cg = 16'($urandom_range(0, 255));
				end
				4: begin
					wg = 16'(WordGasRst);
					qd = QuadDivRst;
					cg = 16'(CopyGasRst);
				end
				default: begin
					// upper data bits are dropped by the narrow registers
					wg = 16'($urandom_range(0, 65535));
					qd = 16'($urandom_range(1, 65535));
					cg = 16'($urandom_range(0, 65535));
				end
			endcase
			write_reg(CFG_WORD_GAS, wg);
			write_reg(CFG_QUAD_DIV, qd);
			write_reg(CFG_COPY_GAS, cg);
			// idling per phase, none at all in the last one
			case (phase)
				0: begin gap_pct = 25; stall_pct = 25; end
				1: begin gap_pct = 0; stall_pct = 30; end
				2: begin gap_pct = 10; stall_pct = 10; end
				3: begin gap_pct = 30; stall_pct = 0; end
				4: begin gap_pct = 15; stall_pct = 15; end
				default: begin gap_pct = 0; stall_pct = 0; end
			endcase
			for (int n = 0; n < PhaseItems; n++) begin
				if ($urandom_range(0, 99) < gap_pct)
					pause_sender($urandom_range(1, 19));
				send_item(random_item(), 1'b0, '0);
			end
		end

		drain();
		// room for any stray result after the last one owed
		repeat (80) @(posedge clk);
		if (errors == 0 && gas_reports.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
sv/megm_pkg.sv
sv/megm_if.sv
sv/megm_ctrl.sv
sv/megm_datapath.sv
sv/memory_expansion_gas_meter.sv
test/memory_expansion_gas_meter_test.sv
